[hdl/setq_pkg.sv]
`timescale 1ns / 1ps
// Package for the sorted event-time queue: field widths, action codes,
// transaction and entry structs. No dependencies.
package setq_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_W        = 16;
  localparam int unsigned TIME_W       = 64;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned ACTION_W     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_QUERY  = 2'd2
  } setq_act_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    event_key;
    logic [TIME_W-1:0]   event_time;
  } setq_in_t;

  typedef struct packed {
    logic               min_valid;
    logic [KEY_W-1:0]   min_key;
    logic [TIME_W-1:0]  min_time;
    logic               found;
    logic [TIME_W-1:0]  found_time;
    logic [COUNT_W-1:0] entry_count;
    logic               dropped;
  } setq_out_t;

  // One stored pair.
  typedef struct packed {
    logic [KEY_W-1:0]  ev_key;
    logic [TIME_W-1:0] ev_time;
  } setq_entry_t;

  // Status from the shared compare unit.
  typedef struct packed {
    logic lt;
    logic gt;
    logic key_eq;
  } setq_cmp_t;

endpackage

[hdl/setq_store.sv]
`timescale 1ns / 1ps
// Entry memory of the event-time queue: one write port, one registered read port.
// Depends on setq_pkg.
module setq_store #(
  parameter int unsigned DEPTH = setq_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  setq_pkg::setq_entry_t wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output setq_pkg::setq_entry_t rdata_o
);

  setq_pkg::setq_entry_t mem [DEPTH];
  setq_pkg::setq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/setq_cmp.sv]
`timescale 1ns / 1ps
// Shared compare unit: stored entry against the transaction's time and key.
// Depends on setq_pkg.
module setq_cmp (
  input  setq_pkg::setq_entry_t entry_i,
  input  setq_pkg::setq_entry_t ref_i,
  output setq_pkg::setq_cmp_t   res_o
);

  always_comb begin
    res_o.lt     = entry_i.ev_time < ref_i.ev_time;
    res_o.gt     = entry_i.ev_time > ref_i.ev_time;
    res_o.key_eq = entry_i.ev_key == ref_i.ev_key;
  end

endmodule

[hdl/sorted_event_time_queue_top.sv]
`timescale 1ns / 1ps
// Sorted event-time queue top level: sequencer, entry memory and compare unit.
// Depends on setq_pkg, setq_store, setq_cmp.
//
// Holds up to CAPACITY key/time pairs in ascending time order. A new entry,
// or an updated one moving toward the head, goes after entries of equal time;
// one moving toward the tail goes before them. A transaction is taken when
// start is high and busy is low; busy then stays high until the work is done,
// and the result is on out_o with done_o high for one cycle, in the same cycle
// that busy falls. The receiver cannot stall. Every entry access goes through
// the one memory read port and the one comparator, one entry per cycle. A full
// insert is dropped and flagged without touching the store.
module sorted_event_time_queue_top #(
  parameter int unsigned CAPACITY = setq_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  setq_pkg::setq_in_t  in_i,
  output logic               done_o,
  output setq_pkg::setq_out_t out_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIND  = 5'b00010,
    S_WALK  = 5'b00100,
    S_PLACE = 5'b01000,
    S_LOOK  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         held_q, held_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         chk_q, chk_d;
  logic                  chk_v_q, chk_v_d;
  logic                  dir_q, dir_d;     // 1: walk toward later entries
  logic [AW-1:0]         place_q, place_d;
  logic                  drop_q, drop_d;
  logic                  done_q, done_d;
  setq_pkg::setq_entry_t new_q, new_d;
  setq_pkg::setq_entry_t min_q, min_d;
  setq_pkg::setq_out_t   out_q, out_d;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  setq_pkg::setq_entry_t mem_wdata;
  setq_pkg::setq_entry_t rdata;
  setq_pkg::setq_cmp_t   cmp;

  logic [CW-1:0] held_m1, chk_p1, chk_m1;
  logic          at_last, hit, scan_end, shift, bound, go_on;
  setq_pkg::setq_entry_t min_sel;

  setq_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  setq_cmp u_cmp (
    .entry_i (rdata),
    .ref_i   (new_q),
    .res_o   (cmp)
  );

  assign busy    = (state_q != S_IDLE);
  assign held_m1 = held_q - CW'(1);
  assign chk_p1  = chk_q + CW'(1);
  assign chk_m1  = chk_q - CW'(1);
  assign at_last = (chk_q == held_m1);
  assign hit     = chk_v_q && cmp.key_eq;
  // linear scan ends on first key match, after the last held entry, or at once if empty
  assign scan_end = (held_q == '0) || hit || (chk_v_q && at_last);
  assign shift   = dir_q ? cmp.lt : cmp.gt;
  assign bound   = dir_q ? at_last : (chk_q == '0);
  assign min_sel = (chk_v_q && (chk_q == '0)) ? rdata : min_q;

  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    cnt_d     = cnt_q;
    chk_d     = chk_q;
    chk_v_d   = chk_v_q;
    dir_d     = dir_q;
    place_d   = place_q;
    drop_d    = drop_q;
    done_d    = 1'b0;
    new_d     = new_q;
    min_d     = min_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_waddr = place_q;
    mem_wdata = new_q;
    go_on     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          new_d.ev_key  = in_i.event_key;
          new_d.ev_time = in_i.event_time;
          drop_d        = 1'b0;
          cnt_d         = '0;
          chk_v_d       = 1'b0;
          if (in_i.action == setq_pkg::ACT_INSERT) begin
            if (held_q == CW'(CAPACITY)) begin
              drop_d  = 1'b1;
              state_d = S_LOOK;
            end else begin
              held_d = held_q + CW'(1);
              dir_d  = 1'b0;
              if (held_q == '0) begin
                place_d = '0;
                state_d = S_PLACE;
              end else begin
                cnt_d   = held_m1;
                state_d = S_WALK;
              end
            end
          end else if (in_i.action == setq_pkg::ACT_UPDATE) begin
            state_d = S_FIND;
          end else begin
            state_d = S_LOOK;
          end
        end
      end

      S_FIND: begin
        if (scan_end) begin
          chk_v_d = 1'b0;
          if (hit) begin
            // old time above new one: entry moves toward the head
            if (cmp.gt) begin
              dir_d = 1'b0;
              if (chk_q == '0) begin
                place_d = '0;
                state_d = S_PLACE;
              end else begin
                cnt_d   = chk_m1;
                state_d = S_WALK;
              end
            end else begin
              dir_d = 1'b1;
              if (at_last) begin
                place_d = chk_q[AW-1:0];
                state_d = S_PLACE;
              end else begin
                cnt_d   = chk_p1;
                state_d = S_WALK;
              end
            end
          end else begin
            cnt_d   = '0;
            state_d = S_LOOK;
          end
        end else begin
          cnt_d   = cnt_q + CW'(1);
          chk_d   = cnt_q;
          chk_v_d = 1'b1;
        end
      end

      S_WALK: begin
        if (chk_v_q) begin
          if (shift) begin
            mem_we    = 1'b1;
            mem_waddr = dir_q ? chk_m1[AW-1:0] : chk_p1[AW-1:0];
            mem_wdata = rdata;
            if (bound) begin
              place_d = chk_q[AW-1:0];
              chk_v_d = 1'b0;
              state_d = S_PLACE;
            end else begin
              go_on = 1'b1;
            end
          end else begin
            place_d = dir_q ? chk_m1[AW-1:0] : chk_p1[AW-1:0];
            chk_v_d = 1'b0;
            state_d = S_PLACE;
          end
        end else begin
          go_on = 1'b1;
        end
        if (go_on) begin
          cnt_d   = dir_q ? (cnt_q + CW'(1)) : (cnt_q - CW'(1));
          chk_d   = cnt_q;
          chk_v_d = 1'b1;
        end
      end

      S_PLACE: begin
        mem_we  = 1'b1;
        cnt_d   = '0;
        chk_v_d = 1'b0;
        state_d = S_LOOK;
      end

      S_LOOK: begin
        if (chk_v_q && (chk_q == '0)) begin
          min_d = rdata;
        end
        if (scan_end) begin
          out_d.min_valid   = (held_q != '0);
          out_d.min_key     = (held_q != '0) ? min_sel.ev_key : '0;
          out_d.min_time    = (held_q != '0) ? min_sel.ev_time : '0;
          out_d.found       = hit;
          out_d.found_time  = hit ? rdata.ev_time : '0;
          out_d.entry_count = setq_pkg::COUNT_W'(held_q);
          out_d.dropped     = drop_q;
          done_d            = 1'b1;
          chk_v_d           = 1'b0;
          state_d           = S_IDLE;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          chk_d   = cnt_q;
          chk_v_d = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      held_q  <= '0;
      cnt_q   <= '0;
      chk_q   <= '0;
      chk_v_q <= 1'b0;
      dir_q   <= 1'b0;
      place_q <= '0;
      drop_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      cnt_q   <= cnt_d;
      chk_q   <= chk_d;
      chk_v_q <= chk_v_d;
      dir_q   <= dir_d;
      place_q <= place_d;
      drop_q  <= drop_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    min_q <= min_d;
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

[hdl/setq_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the sorted event-time queue, bound to the top level.
// Depends on setq_pkg and sorted_event_time_queue_top.
module setq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input setq_pkg::setq_out_t out_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy fell without a result strobe");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result strobe without a finished transaction");

  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_o.min_valid) |-> ((out_o.min_key == '0) && (out_o.min_time == '0)))
    else $error("empty queue reported a nonzero minimum");

  a_absent_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_o.found) |-> (out_o.found_time == '0))
    else $error("absent key reported a nonzero time");

endmodule

bind sorted_event_time_queue_top setq_checker u_setq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .out_o  (out_o)
);
